// ----- design/deq_pkg.sv -----
// shared types and codes for the double-ended queue
`default_nettype none

package deq_pkg;

  localparam int WORD_W  = 64;
  localparam int LEVEL_W = 5;

  // request codes
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [LEVEL_W-1:0]       fill_level;
  } out_word_t;

  // move broadcast to every cell, at most one bit set
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/deq_cell.sv -----
// one storage cell of the deque chain
`default_nettype none

module deq_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::cell_ctl_t                ctl,
  input  logic                              prev_valid,
  input  logic signed [deq_pkg::WORD_W-1:0] prev_data,
  input  logic                              next_valid,
  input  logic signed [deq_pkg::WORD_W-1:0] next_data,
  input  logic signed [deq_pkg::WORD_W-1:0] push_value,
  output logic                              valid,
  output logic signed [deq_pkg::WORD_W-1:0] data,
  output logic                              tail
);
  import deq_pkg::*;

  logic load;

  // first free cell takes a back push
  assign load = !valid && prev_valid;
  // last occupied cell
  assign tail = valid && !next_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.push_front) begin
      valid <= prev_valid;
    end else if (ctl.push_back) begin
      valid <= valid || prev_valid;
    end else if (ctl.pop_front) begin
      valid <= next_valid;
    end else if (ctl.pop_back) begin
      valid <= valid && next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      data <= prev_data;
    end else if (ctl.push_back && load) begin
      data <= push_value;
    end else if (ctl.pop_front) begin
      data <= next_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/double_ended_queue_unit.sv -----
// double-ended queue of signed 64-bit words held in a chain of cells
//
// usage
//   raise start with a request word on req (req_type and push_value); the word
//   is taken at a clock edge where start is high and busy is low. busy stays
//   low, so a request may be issued in every cycle.
//   each request gives one result word on result, shown for exactly one cycle
//   with done high, in the cycle after the request is taken. the receiver cannot
//   hold results off; it must take each word in the cycle it is shown.
//   throughput is one request per cycle: every request is one move of the
//   cell chain (shift toward the back, shift toward the front, or a write
//   into the first free cell).
//   front is always cell 0, stored words sit in cells 0 .. count-1 and each
//   cell keeps a valid bit; a back pop reads the one cell marked as tail.
//   a pop from an empty deque reports the empty status, a push into a full
//   deque is dropped and reports the full status; the state is unchanged.
//   reset (synchronous, active high) clears every valid bit and the count
//   and drops any result in flight; stored data is not cleared.
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_word_t  req,
  output logic               done,
  output deq_pkg::out_word_t result
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // per-cell chain signals
  logic [DEPTH-1:0]         cell_valid;
  logic signed [WORD_W-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]         cell_tail;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;

  logic      accept;
  logic      is_push;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;

  logic signed [WORD_W-1:0] back_value;
  logic signed [WORD_W-1:0] pop_value_next;
  logic [1:0]               status_next;

  // one move of the chain per cycle, never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_push = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_PUSH_BACK);
  assign full    = cell_valid[DEPTH-1];
  assign empty   = !cell_valid[0];

  // decode the request into a chain move, refused moves leave the cells alone
  always_comb begin
    ctl = '0;
    if (accept) begin
      case (req.req_type)
        REQ_PUSH_FRONT: ctl.push_front = !full;
        REQ_PUSH_BACK:  ctl.push_back  = !full;
        REQ_POP_FRONT:  ctl.pop_front  = !empty;
        REQ_POP_BACK:   ctl.pop_back   = !empty;
        default:        ctl = '0;
      endcase
    end
  end

  // the chain; cell 0 sees the new word as its left neighbor so a front push
  // shifts it in, and the last cell sees an empty right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_valid;
    logic signed [WORD_W-1:0] prev_data;
    logic                     next_valid;
    logic signed [WORD_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_data  = req.push_value;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_valid(prev_valid),
      .prev_data (prev_data),
      .next_valid(next_valid),
      .next_data (next_data),
      .push_value(req.push_value),
      .valid     (cell_valid[i]),
      .data      (cell_data[i]),
      .tail      (cell_tail[i])
    );
  end

  // the tail mark is one-hot when not empty, so an and-or picks the back word
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {WORD_W{cell_tail[i]}});
    end
  end

  // result of the request taken this cycle
  always_comb begin
    fill_count_next = fill_count;
    pop_value_next  = '0;
    status_next     = ST_OK;
    if (is_push) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        fill_count_next = fill_count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        fill_count_next = fill_count - CNT_W'(1);
        pop_value_next  = (req.req_type == REQ_POP_FRONT) ? cell_data[0] : back_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        fill_count <= fill_count_next;
      end
    end
  end

  // result word register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      result.pop_value  <= pop_value_next;
      result.status     <= status_next;
      result.fill_level <= LEVEL_W'(fill_count_next);
    end
  end

  // the number of set valid bits matches the count
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(cell_valid)) == fill_count)
    else $error("cell valid bits disagree with fill count");

  // at most one cell is the tail
  a_tail_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_tail))
    else $error("more than one tail cell");

  // every taken request gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request without result");

  // a refused request leaves the count untouched
  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> $stable(fill_count))
    else $error("count moved on a refused request");

endmodule

`default_nettype wire
